// ----- rtl/core/mm_pkg.sv -----
// shared types and codes for the matrix multiply block
package mm_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int ELEM_BITS_DEF = 32;
    localparam int CFG_BITS      = 4;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_A_ROWS = 2'd0,
        REG_A_COLS = 2'd1,
        REG_B_ROWS = 2'd2,
        REG_B_COLS = 2'd3
    } t_reg;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FEED  = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_ERR   = 5'b10000
    } t_state;

    // control tag that travels along the cell chain with each left element
    typedef struct packed {
        logic vld;
        logic first;
        logic lastk;
    } t_tag;

endpackage

// ----- rtl/core/mm_cell.sv -----
// one multiply-accumulate cell holding one column of the right matrix
module mm_cell #(
    parameter int CELL_IDX  = 0,
    parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
    parameter int ELEM_BITS = mm_pkg::ELEM_BITS_DEF,
    parameter int IDX_W     = $clog2(MAX_DIM)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_bwe,
    input  logic [IDX_W-1:0]     i_bcol,
    input  logic [IDX_W-1:0]     i_bk,
    input  logic [ELEM_BITS-1:0] i_bdata,
    input  mm_pkg::t_tag         i_tag,
    input  logic [IDX_W-1:0]     i_k,
    input  logic [ELEM_BITS-1:0] i_a,
    output mm_pkg::t_tag         o_tag,
    output logic [IDX_W-1:0]     o_k,
    output logic [ELEM_BITS-1:0] o_a,
    output logic [ELEM_BITS-1:0] o_acc,
    output logic                 o_done
);

    logic [ELEM_BITS-1:0] r_bmem [MAX_DIM];
    logic [MAX_DIM-1:0]   r_bvld;
    logic [ELEM_BITS-1:0] b_val;
    mm_pkg::t_tag         r_tag;
    mm_pkg::t_tag         r_ptag;
    logic [IDX_W-1:0]     r_k;
    logic [ELEM_BITS-1:0] r_a;
    logic [ELEM_BITS-1:0] r_p;
    logic [ELEM_BITS-1:0] r_acc;
    logic                 r_done;

    // never-written entries read as zero
    assign b_val = r_bvld[i_k] ? r_bmem[i_k] : '0;

    always_ff @(posedge i_clk) begin
        if (i_bwe && (i_bcol == IDX_W'(CELL_IDX))) begin
            r_bmem[i_bk] <= i_bdata;
        end
        r_k <= i_k;
        r_a <= i_a;
        r_p <= i_a * b_val;
        if (r_ptag.vld) begin
            r_acc <= r_ptag.first ? r_p : r_acc + r_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld <= '0;
            r_tag  <= '0;
            r_ptag <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_bwe && (i_bcol == IDX_W'(CELL_IDX))) begin
                r_bvld[i_bk] <= 1'b1;
            end
            r_tag  <= i_tag;
            r_ptag <= i_tag;
            r_done <= r_ptag.vld & r_ptag.lastk;
        end
    end

    assign o_tag  = r_tag;
    assign o_k    = r_k;
    assign o_a    = r_a;
    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// ----- rtl/core/matrix_multiply.sv -----
// matrix multiply top level: left store, sequencer, cell chain and result register
//
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_command i_row_index i_col_index i_element
// result    out        o_valid / i_stall    o_out_row o_out_col o_product o_last o_error
// config    in         i_cfg_we             i_cfg_index i_cfg_data
//
// load words are taken back to back while idle
// a compute word runs row by row: per row the left store streams a_cols words
// into the cell chain and the far cell finishes the row; the sequencer then enters
// its drain state and b_cols words drain from the cells through the result register,
// one per cycle when not stalled
// synchronous active-low reset clears both stores through per-entry valid bits
// input is stalled from a compute word until its last result is loaded out
module matrix_multiply #(
    parameter int MAX_DIM   = mm_pkg::MAX_DIM_DEF,
    parameter int ELEM_BITS = mm_pkg::ELEM_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [2:0]         i_row_index,
    input  logic [2:0]         i_col_index,
    input  logic signed [31:0] i_element,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_out_row,
    output logic [2:0]         o_out_col,
    output logic signed [31:0] o_product,
    output logic               o_last,
    output logic               o_error,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    // configuration, held clamped to 1..MAX_DIM
    logic [DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [DIM_W-1:0] cfg_dim;

    // left store
    logic [ELEM_BITS-1:0] r_amem [DEPTH];
    logic [DEPTH-1:0]     r_avld;
    logic [ELEM_BITS-1:0] r_rd_data;
    logic                 r_rd_ok;
    mm_pkg::t_tag         r_rd_tag;
    logic [IDX_W-1:0]     r_rd_k;

    // sequencer
    mm_pkg::t_state   r_state, n_state;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_k, n_k;

    // result register
    logic               r_out_vld, n_out_vld;
    logic [2:0]         r_out_row, n_out_row;
    logic [2:0]         r_out_col, n_out_col;
    logic signed [31:0] r_out_prod, n_out_prod;
    logic               r_out_last, n_out_last;
    logic               r_out_err, n_out_err;

    logic in_acc, out_free;
    logic a_fit, b_fit;
    logic last_k, last_row, last_col;
    logic feed_rd;
    logic b_we;

    // cell chain links
    mm_pkg::t_tag         ch_tag [MAX_DIM+1];
    logic [IDX_W-1:0]     ch_k   [MAX_DIM+1];
    logic [ELEM_BITS-1:0] ch_a   [MAX_DIM+1];
    logic [ELEM_BITS-1:0] cell_acc  [MAX_DIM];
    logic [MAX_DIM-1:0]   cell_done;

    assign o_stall  = (r_state != mm_pkg::ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_vld || !i_stall;

    assign a_fit = (4'(i_row_index) < 4'(r_a_rows)) && (4'(i_col_index) < 4'(r_a_cols));
    assign b_fit = (4'(i_row_index) < 4'(r_b_rows)) && (4'(i_col_index) < 4'(r_b_cols));
    assign b_we  = in_acc && (i_command == mm_pkg::CMD_LOAD_B) && b_fit;

    assign last_k   = (r_k == IDX_W'(r_a_cols - 1'b1));
    assign last_row = (r_row == IDX_W'(r_a_rows - 1'b1));
    assign last_col = (r_col == IDX_W'(r_b_cols - 1'b1));
    assign feed_rd  = (r_state == mm_pkg::ST_FEED);

    // zero maps to one, anything beyond the array size saturates
    always_comb begin
        if (i_cfg_data == 4'd0) begin
            cfg_dim = DIM_W'(1);
        end else if (i_cfg_data > 4'(DIM_MAX)) begin
            cfg_dim = DIM_MAX;
        end else begin
            cfg_dim = DIM_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= DIM_MAX;
            r_a_cols <= DIM_MAX;
            r_b_rows <= DIM_MAX;
            r_b_cols <= DIM_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mm_pkg::REG_A_ROWS: r_a_rows <= cfg_dim;
                mm_pkg::REG_A_COLS: r_a_cols <= cfg_dim;
                mm_pkg::REG_B_ROWS: r_b_rows <= cfg_dim;
                mm_pkg::REG_B_COLS: r_b_cols <= cfg_dim;
                default: ;
            endcase
        end
    end

    // left store: written by loads, read one element per cycle while feeding
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_command == mm_pkg::CMD_LOAD_A) && a_fit) begin
            r_amem[{i_row_index[IDX_W-1:0], i_col_index[IDX_W-1:0]}] <=
                ELEM_BITS'(i_element);
        end
        r_rd_data <= r_amem[{r_row, r_k}];
        r_rd_k    <= r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avld   <= '0;
            r_rd_ok  <= 1'b0;
            r_rd_tag <= '0;
        end else begin
            if (in_acc && (i_command == mm_pkg::CMD_LOAD_A) && a_fit) begin
                r_avld[{i_row_index[IDX_W-1:0], i_col_index[IDX_W-1:0]}] <= 1'b1;
            end
            r_rd_ok        <= r_avld[{r_row, r_k}];
            r_rd_tag.vld   <= feed_rd;
            r_rd_tag.first <= feed_rd && (r_k == '0);
            r_rd_tag.lastk <= feed_rd && last_k;
        end
    end

    // head of the chain: a never-written left entry reads as zero
    assign ch_tag[0] = r_rd_tag;
    assign ch_k[0]   = r_rd_k;
    assign ch_a[0]   = r_rd_ok ? r_rd_data : '0;

    // cell c accumulates product column c of the current row
    for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
        mm_cell #(
            .CELL_IDX (c),
            .MAX_DIM  (MAX_DIM),
            .ELEM_BITS(ELEM_BITS),
            .IDX_W    (IDX_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_bwe  (b_we),
            .i_bcol (i_col_index[IDX_W-1:0]),
            .i_bk   (i_row_index[IDX_W-1:0]),
            .i_bdata(ELEM_BITS'(i_element)),
            .i_tag  (ch_tag[c]),
            .i_k    (ch_k[c]),
            .i_a    (ch_a[c]),
            .o_tag  (ch_tag[c+1]),
            .o_k    (ch_k[c+1]),
            .o_a    (ch_a[c+1]),
            .o_acc  (cell_acc[c]),
            .o_done (cell_done[c])
        );
    end

    // sequencer and result register
    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_k        = r_k;
        n_out_vld  = r_out_vld && i_stall;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_prod = r_out_prod;
        n_out_last = r_out_last;
        n_out_err  = r_out_err;
        unique case (r_state)
            mm_pkg::ST_IDLE: begin
                if (in_acc && (i_command == mm_pkg::CMD_COMPUTE)) begin
                    n_row = '0;
                    n_k   = '0;
                    if (r_a_cols != r_b_rows) begin
                        n_state = mm_pkg::ST_ERR;
                    end else begin
                        n_state = mm_pkg::ST_FEED;
                    end
                end
            end
            mm_pkg::ST_FEED: begin
                n_k = r_k + 1'b1;
                if (last_k) begin
                    n_state = mm_pkg::ST_WAIT;
                end
            end
            mm_pkg::ST_WAIT: begin
                // the far cell finishes last
                if (cell_done[MAX_DIM-1]) begin
                    n_col   = '0;
                    n_state = mm_pkg::ST_DRAIN;
                end
            end
            mm_pkg::ST_DRAIN: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_row  = 3'(r_row);
                    n_out_col  = 3'(r_col);
                    n_out_prod = 32'(signed'(cell_acc[r_col]));
                    n_out_last = last_row && last_col;
                    n_out_err  = 1'b0;
                    n_col      = r_col + 1'b1;
                    if (last_col) begin
                        if (last_row) begin
                            n_state = mm_pkg::ST_IDLE;
                        end else begin
                            n_row   = r_row + 1'b1;
                            n_k     = '0;
                            n_state = mm_pkg::ST_FEED;
                        end
                    end
                end
            end
            mm_pkg::ST_ERR: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_row  = '0;
                    n_out_col  = '0;
                    n_out_prod = '0;
                    n_out_last = 1'b1;
                    n_out_err  = 1'b1;
                    n_state    = mm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mm_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
            r_k       <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_row     <= n_row;
            r_col     <= n_col;
            r_k       <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_prod <= n_out_prod;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    assign o_valid   = r_out_vld;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;
    assign o_product = r_out_prod;
    assign o_last    = r_out_last;
    assign o_error   = r_out_err;

    // an error word carries no product and closes the run
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_last && (o_product == '0))
        else $error("error word malformed");

    // a row can only complete while the sequencer waits for it
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_done[MAX_DIM-1] |-> (r_state == mm_pkg::ST_WAIT))
        else $error("row finished outside wait");

    // feeding never reads past the inner dimension
    a_feed_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mm_pkg::ST_FEED) |-> (DIM_W'(r_k) < r_a_cols))
        else $error("feed index beyond inner dimension");

endmodule
